// ===== hw/rtl/average_tie_rank_int_u_unit_macros.svh =====
// Assertion macros for the average tie rank unit.
`ifndef AVERAGE_TIE_RANK_INT_U_UNIT_MACROS_SVH
`define AVERAGE_TIE_RANK_INT_U_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ATR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ATR_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ATR_ASSERT(label, clk, rst, prop, msg)
`define ATR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/atr_pkg.sv =====
// ----------------------------------------------------------------------------
// atr_pkg
// Types and constants shared by the average tie rank unit.
// ----------------------------------------------------------------------------
package atr_pkg;
   localparam int MAX_ROWS = 64;
   localparam int IDX_W = $clog2(MAX_ROWS);
   localparam int CNT_W = $clog2(MAX_ROWS + 1);
   localparam logic [15:0] RANK_OFFSET_RESET = 16'd24576;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RANK,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctrl_type;
endpackage

// ===== hw/rtl/average_tie_rank_int_u_unit.sv =====
// ----------------------------------------------------------------------------
// average_tie_rank_int_u_unit
// Average-tie rank fraction of one column of samples.
// ----------------------------------------------------------------------------
// Sample words are taken while the unit is loading. After the word flagged
// tlast, ranking runs one shared compare a cycle over the single-port store;
// for each row it reads the key, latches it while reading the first row to
// compare, then compares it with every row. Each row then goes through the
// bit-serial divider (rank read, divider start, the quotient bits, quotient
// collect) and leaves as one result word; no sample is taken until the last
// result word of the column leaves. Offset writes are taken only while the
// unit is loading, so a column always uses the offset seen at its tlast.
`include "average_tie_rank_int_u_unit_macros.svh"
module average_tie_rank_int_u_unit
   import atr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   input  logic        req_tlast,   // last_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [5:0] row_index, [21:6] u_value, zero fill
   output logic        rsp_tlast,   // last_result
   output logic        rsp_tuser,   // overflow
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // rank_offset
);
   // stores, read registered
   logic [31:0] store_mem [MAX_ROWS];
   logic [7:0]  rank_mem  [MAX_ROWS];
   logic [31:0] rd_k, key_i_ff;
   logic [7:0]  rank_rd;

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] i_ff, i_in, k_ff, k_in;
   logic        ovf_ff, ovf_in;
   logic [15:0] off_ff;
   logic [7:0]  acc_ff, acc_in;
   logic [1:0]  ph_ff, ph_in;      // sub-step inside a row
   logic        out_v_ff, out_v_in;
   logic [15:0] u_ff, u_in;
   logic        dstart;
   logic [39:0] dividend;
   logic [23:0] divisor;
   div_ctrl_type dctrl;
   logic [15:0] quot;
   logic [IDX_W-1:0] rd_addr;
   logic        wr_rank;
   logic [23:0] num;
   logic        acc_k;

   assign csr_ready  = (state_ff == ST_LOAD);
   assign req_tready = (state_ff == ST_LOAD);

   always_ff @(posedge clock) begin
      if (reset) off_ff <= RANK_OFFSET_RESET;
      else if (csr_valid && csr_ready) off_ff <= csr_data;
   end

   // keep the store port on one address per cycle; fetch the next k ahead
   always_comb begin
      rd_addr = (state_ff == ST_RANK && ph_ff != 2'd0) ? k_in : i_ff;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready && count_ff < CNT_W'(MAX_ROWS))
         store_mem[count_ff[IDX_W-1:0]] <= req_tdata;
      rd_k    <= store_mem[rd_addr];
      if (wr_rank) rank_mem[i_ff] <= acc_in;
      rank_rd <= rank_mem[i_ff];
   end

   // signed compare on store words: less adds 2, equal adds 1
   assign acc_k = 1'b1;
   assign num = {1'b0, rank_rd, 15'd0} - {8'd0, off_ff};
   assign dividend = ({1'b0, rank_rd, 15'd0} > {8'd0, off_ff}) ? {num, 16'd0} : 40'd0;
   assign divisor  = {count_ff, 16'd0} + 24'h10000 - {7'd0, off_ff, 1'b0};

   always_comb begin
      state_in = state_ff; count_in = count_ff; i_in = i_ff; k_in = k_ff;
      ovf_in = ovf_ff; acc_in = acc_ff; ph_in = ph_ff; out_v_in = out_v_ff;
      u_in = u_ff; dstart = 1'b0; wr_rank = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               if (count_ff < CNT_W'(MAX_ROWS)) count_in = count_ff + 1'b1;
               else ovf_in = 1'b1;
               if (req_tlast) begin
                  if (count_in == '0) begin
                     ovf_in = 1'b0; count_in = '0;   // nothing stored
                  end else begin
                     state_in = ST_RANK; i_in = '0; k_in = '0; ph_in = 2'd0;
                  end
               end
            end
         end
         ST_RANK: begin
            // phase 0: read row i; phase 1: latch key, read k; phase 2+: compare
            case (ph_ff)
               2'd0: ph_in = 2'd1;
               2'd1: begin ph_in = 2'd2; acc_in = 8'd1; end
               default: begin
                  if ($signed(rd_k) < $signed(key_i_ff)) acc_in = acc_ff + 8'd2;
                  else if (rd_k == key_i_ff) acc_in = acc_ff + 8'd1;
                  ph_in = 2'd3;
                  if (CNT_W'(k_ff) + 1'b1 == count_ff) begin
                     wr_rank = acc_k; k_in = '0; ph_in = 2'd0;
                     if (CNT_W'(i_ff) + 1'b1 == count_ff) begin
                        i_in = '0; state_in = ST_DIVIDE;
                     end else i_in = i_ff + 1'b1;
                  end else k_in = k_ff + 1'b1;
               end
            endcase
         end
         ST_DIVIDE: begin
            case (ph_ff)
               2'd0: ph_in = 2'd1;          // rank read in flight
               2'd1: begin dstart = 1'b1; ph_in = 2'd2; end
               2'd2: ph_in = 2'd3;
               default: begin
                  if (!dctrl.busy) begin
                     u_in = quot; out_v_in = 1'b1; state_in = ST_EMIT;
                  end
               end
            endcase
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               out_v_in = 1'b0; ph_in = 2'd0;
               if (CNT_W'(i_ff) + 1'b1 == count_ff) begin
                  state_in = ST_LOAD; count_in = '0; ovf_in = 1'b0; i_in = '0;
               end else begin
                  i_in = i_ff + 1'b1; state_in = ST_DIVIDE;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // key of row i comes from the read issued in phase 0
   always_ff @(posedge clock) begin
      if (state_ff == ST_RANK && ph_ff == 2'd1) key_i_ff <= rd_k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; count_ff <= '0; ovf_ff <= 1'b0; out_v_ff <= 1'b0;
         i_ff <= '0; k_ff <= '0; ph_ff <= 2'd0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ovf_ff <= ovf_in;
         out_v_ff <= out_v_in; i_ff <= i_in; k_ff <= k_in; ph_ff <= ph_in;
      end
      acc_ff <= acc_in;
      u_ff   <= u_in;
   end

   atr_divider u_div (
      .clock(clock), .reset(reset), .start(dstart), .dividend(dividend),
      .divisor(divisor), .ctrl(dctrl), .quotient(quot)
   );

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {2'b00, u_ff, i_ff};
   assign rsp_tlast  = (CNT_W'(i_ff) + 1'b1 == count_ff);
   assign rsp_tuser  = ovf_ff;

   `ATR_ASSERT(a_no_accept_busy, clock, reset, (state_ff != ST_LOAD) |-> !req_tready, "ready while busy")
   `ATR_ASSERT(a_valid_emit, clock, reset, rsp_tvalid |-> (state_ff == ST_EMIT), "valid outside emit")
   `ATR_ASSERT(a_count_cap, clock, reset, count_ff <= CNT_W'(MAX_ROWS), "row count beyond store")
   `ATR_ASSERT(a_div_start, clock, reset, dctrl.start |=> dctrl.busy, "divider did not start")
endmodule

// ===== hw/rtl/atr_divider.sv =====
// ----------------------------------------------------------------------------
// atr_divider
// Restoring divider, one quotient bit per cycle, 16-bit saturated quotient.
// ----------------------------------------------------------------------------
module atr_divider
   import atr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] dividend,   // num * 65536
   input  logic [23:0] divisor,
   output div_ctrl_type ctrl,
   output logic [15:0] quotient
);
   logic [39:0] rem_ff, rem_in;
   logic [40:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [63:0] dsor_ff, dsor_in;
   logic [64:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      dsor_in = dsor_ff;
      trial   = {25'd0, rem_ff} - {1'b0, dsor_ff};
      if (start) begin
         rem_in  = dividend;
         quo_in  = '0;
         cnt_in  = 6'd40;
         busy_in = 1'b1;
         dsor_in = {divisor, 40'd0};
      end else if (busy_ff) begin
         // shift divisor down; take bit if it fits
         if (!trial[64]) begin
            rem_in = trial[39:0];
            quo_in = {quo_ff[39:0], 1'b1};
         end else begin
            quo_in = {quo_ff[39:0], 1'b0};
         end
         dsor_in = dsor_ff >> 1;
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsor_ff <= dsor_in;
   end

   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
   assign quotient   = (quo_ff[40:16] != '0) ? 16'hFFFF : quo_ff[15:0];
endmodule
